// ----- hdl/ftqp_pkg.sv -----
// ----------------------------------------------------------------------------
// ftqp_pkg
// operation codes, pointer selectors, queue geometry and write-enable group
// for the fetch target queue pointer unit
// ----------------------------------------------------------------------------
package ftqp_pkg;

    // queue geometry, tied to the 6-bit index and 16-bit mispredict ports
    localparam int DEPTH = 32;
    localparam int SLOTS = 16;

    typedef enum logic [3:0] {
        MODE_PUSH      = 4'd0,
        MODE_S2_UPDATE = 4'd1,
        MODE_S3_UPDATE = 4'd2,
        MODE_FETCH_POP = 4'd3,
        MODE_PF_POP    = 4'd4,
        MODE_RETIRE    = 4'd5,
        MODE_TARGET    = 4'd6,
        MODE_COMMIT_ST = 4'd7,
        MODE_HIT       = 4'd8,
        MODE_CFI       = 4'd9,
        MODE_MISPRED   = 4'd10,
        MODE_RECOVER   = 4'd11,
        MODE_READ      = 4'd12
    } t_mode;

    typedef enum logic [2:0] {
        SEL_S1       = 3'd0,
        SEL_S2       = 3'd1,
        SEL_S3       = 3'd2,
        SEL_FETCH    = 3'd3,
        SEL_PREFETCH = 3'd4
    } t_which;

    localparam logic [1:0] HIT_CODE = 2'd1;

    // per-field write enables into the entry store
    typedef struct packed {
        logic start;
        logic target;
        logic cfi;
        logic hit;
        logic cs;
        logic mp;
    } t_wr_en;

endpackage

// ----- hdl/ftqp_store.sv -----
// ----------------------------------------------------------------------------
// ftqp_store
// entry storage with one read/write address, plus per-entry committed and
// predictor-update bits for the commit-side flags
// ----------------------------------------------------------------------------
module ftqp_store
    import ftqp_pkg::*;
(
    input  logic                       i_clk,
    input  logic [$clog2(DEPTH)-1:0]   i_addr,
    input  t_wr_en                     i_we,
    input  logic [63:0]                i_start_d,
    input  logic [63:0]                i_target_d,
    input  logic [4:0]                 i_cfi_d,
    input  logic [1:0]                 i_hit_d,
    input  logic [2*SLOTS-1:0]         i_cs_d,
    input  logic [SLOTS-1:0]           i_mp_d,
    input  logic [$clog2(DEPTH)-1:0]   i_head,
    input  logic [$clog2(DEPTH)-1:0]   i_next,
    output logic [63:0]                o_start,
    output logic [63:0]                o_target,
    output logic [4:0]                 o_cfi,
    output logic [1:0]                 o_hit,
    output logic [2*SLOTS-1:0]         o_cs,
    output logic [SLOTS-1:0]           o_mp,
    output logic                       o_head_done,
    output logic                       o_next_done,
    output logic                       o_head_upd
);

    logic [63:0]        r_start  [DEPTH];
    logic [63:0]        r_target [DEPTH];
    logic [4:0]         r_cfi    [DEPTH];
    logic [1:0]         r_hit    [DEPTH];
    logic [2*SLOTS-1:0] r_cs     [DEPTH];
    logic [SLOTS-1:0]   r_mp     [DEPTH];
    logic [DEPTH-1:0]   r_done;
    logic [DEPTH-1:0]   r_upd;

    logic       n_done;
    logic       n_upd;
    logic [4:0] w_cfi;
    logic [1:0] w_hit;

    assign o_start  = r_start[i_addr];
    assign o_target = r_target[i_addr];
    assign o_cfi    = r_cfi[i_addr];
    assign o_hit    = r_hit[i_addr];
    assign o_cs     = r_cs[i_addr];
    assign o_mp     = r_mp[i_addr];

    // an entry is done when no slot is valid or unfetched (low bit clear)
    always_comb begin
        n_done = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
            if (i_cs_d[2*i]) begin
                n_done = 1'b0;
            end
        end
        w_cfi = i_we.cfi ? i_cfi_d : r_cfi[i_addr];
        w_hit = i_we.hit ? i_hit_d : r_hit[i_addr];
        n_upd = (w_hit == HIT_CODE) || w_cfi[4];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.start) begin
            r_start[i_addr] <= i_start_d;
        end
        if (i_we.target) begin
            r_target[i_addr] <= i_target_d;
        end
        if (i_we.cfi) begin
            r_cfi[i_addr] <= i_cfi_d;
        end
        if (i_we.hit) begin
            r_hit[i_addr] <= i_hit_d;
        end
        if (i_we.cs) begin
            r_cs[i_addr]   <= i_cs_d;
            r_done[i_addr] <= n_done;
        end
        if (i_we.mp) begin
            r_mp[i_addr] <= i_mp_d;
        end
        if (i_we.cfi || i_we.hit) begin
            r_upd[i_addr] <= n_upd;
        end
    end

    // flags as seen after this cycle's write
    assign o_head_done = (i_we.cs && i_addr == i_head) ? n_done : r_done[i_head];
    assign o_next_done = (i_we.cs && i_addr == i_next) ? n_done : r_done[i_next];
    assign o_head_upd  = ((i_we.cfi || i_we.hit) && i_addr == i_head) ? n_upd
                                                                       : r_upd[i_head];

endmodule

// ----- hdl/fetch_target_queue_pointers_unit.sv -----
// ----------------------------------------------------------------------------
// fetch_target_queue_pointers_unit
// circular fetch target queue with wrap-bit pointers for predictor stages,
// fetch, prefetch and commit
// ----------------------------------------------------------------------------
//  channel   | ports                               | handshake
//  ----------+-------------------------------------+---------------------------
//  command   | i_mode .. i_pc                      | start high, busy low
//  result    | o_out_index .. o_order_flags        | o_valid for one cycle
//
//  one command per cycle; busy is never raised
//  result path: the command is captured in the input register, then passes
//  once through pointer update and entry store into the result register,
//  which drives the result ports and o_valid
//  reset clears the pointers and the pipeline valids; entries are undefined
//  until written
//  results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
module fetch_target_queue_pointers_unit
    import ftqp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [3:0]   i_mode,
    input  logic [5:0]   i_index,
    input  logic [2:0]   i_which_pointer,
    input  logic [63:0]  i_start_addr,
    input  logic [63:0]  i_target_addr,
    input  logic         i_cfi_valid,
    input  logic [3:0]   i_cfi_offset,
    input  logic [1:0]   i_hit_status,
    input  logic [3:0]   i_slot,
    input  logic [1:0]   i_commit_state,
    input  logic         i_flag,
    input  logic [63:0]  i_pc,
    output logic         o_valid,
    output logic [5:0]   o_out_index,
    output logic [63:0]  o_out_start_addr,
    output logic [63:0]  o_out_target_addr,
    output logic         o_out_cfi_valid,
    output logic [3:0]   o_out_cfi_offset,
    output logic [1:0]   o_out_hit_status,
    output logic [15:0]  o_mispred_bits,
    output logic [3:0]   o_queue_flags,
    output logic [2:0]   o_commit_flags,
    output logic [1:0]   o_order_flags
);

    localparam int WRAP = 2 * DEPTH;
    localparam int PW   = $clog2(WRAP);
    localparam int EW   = $clog2(DEPTH);
    localparam int SIW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef logic [PW-1:0] t_ptr;

    function automatic t_ptr mod_idx(input logic [5:0] v);
        t_ptr res;
        res = '0;
        for (int i = 0; i < 64; i++) begin
            if (v == 6'(i)) begin
                res = PW'(i % WRAP);
            end
        end
        return res;
    endfunction

    function automatic logic [EW-1:0] slot_of(input t_ptr p);
        return (32'(p) >= DEPTH) ? EW'(32'(p) - DEPTH) : EW'(p);
    endfunction

    function automatic logic wrap_of(input t_ptr p);
        return 32'(p) >= DEPTH;
    endfunction

    function automatic t_ptr adv(input t_ptr p);
        return (32'(p) == WRAP - 1) ? '0 : p + PW'(1);
    endfunction

    function automatic logic is_before(input t_ptr a, input t_ptr b);
        if (wrap_of(a) == wrap_of(b)) begin
            return slot_of(a) < slot_of(b);
        end
        return slot_of(a) > slot_of(b);
    endfunction

    function automatic logic is_full(input t_ptr s, input t_ptr c);
        logic [PW:0] d;
        d = {1'b0, s} + (PW+1)'(WRAP) - {1'b0, c};
        if (32'(d) >= WRAP) begin
            d = d - (PW+1)'(WRAP);
        end
        return 32'(d) == DEPTH;
    endfunction

    // input register
    logic         r_vld;
    logic [3:0]   r_mode;
    logic [5:0]   r_index;
    logic [2:0]   r_which;
    logic [63:0]  r_start;
    logic [63:0]  r_target;
    logic         r_cfi_valid;
    logic [3:0]   r_cfi_offset;
    logic [1:0]   r_hit;
    logic [3:0]   r_slot;
    logic [1:0]   r_cs;
    logic         r_flag;
    logic [63:0]  r_pc;

    // pointers
    t_ptr r_s1, r_s2, r_s3, r_fp, r_pp, r_cp;
    t_ptr n_s1, n_s2, n_s3, n_fp, n_pp, n_cp;

    t_ptr               idx, rep;
    logic               full, fill;
    t_wr_en             we;
    logic [4:0]         w_cfi;
    logic [2*SLOTS-1:0] w_cs;
    logic [SLOTS-1:0]   w_mp;
    logic [63:0]        mp_diff;
    logic [62:0]        mp_off;

    logic [63:0]        rd_start, rd_target;
    logic [4:0]         rd_cfi;
    logic [1:0]         rd_hit;
    logic [2*SLOTS-1:0] rd_cs;
    logic [SLOTS-1:0]   rd_mp;
    logic               head_done, next_done, head_upd;
    t_ptr               nx;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= start && !busy;
        end
        if (start && !busy) begin
            r_mode       <= i_mode;
            r_index      <= i_index;
            r_which      <= i_which_pointer;
            r_start      <= i_start_addr;
            r_target     <= i_target_addr;
            r_cfi_valid  <= i_cfi_valid;
            r_cfi_offset <= i_cfi_offset;
            r_hit        <= i_hit_status;
            r_slot       <= i_slot;
            r_cs         <= i_commit_state;
            r_flag       <= i_flag;
            r_pc         <= i_pc;
        end
    end

    always_comb begin
        idx  = mod_idx(r_index);
        full = is_full(r_s1, r_cp);
        n_s1 = r_s1;
        n_s2 = r_s2;
        n_s3 = r_s3;
        n_fp = r_fp;
        n_pp = r_pp;
        n_cp = r_cp;
        rep  = idx;
        fill = 1'b0;
        we   = '0;
        case (r_mode)
            MODE_PUSH: begin
                rep  = r_s1;
                fill = !full;
                if (!full) begin
                    n_s1 = adv(r_s1);
                end
            end
            MODE_S2_UPDATE: begin
                rep  = r_s2;
                fill = 1'b1;
                n_s2 = adv(r_s2);
            end
            MODE_S3_UPDATE: begin
                rep  = r_s3;
                fill = 1'b1;
                n_s3 = adv(r_s3);
            end
            MODE_FETCH_POP: begin
                rep = r_fp;
                if (r_s1 != r_fp) begin
                    n_fp = adv(r_fp);
                end
            end
            MODE_PF_POP: begin
                rep = r_pp;
                if (r_s1 != r_pp) begin
                    n_pp = adv(r_pp);
                end
            end
            MODE_RETIRE: begin
                rep = r_cp;
                if (r_cp != r_fp) begin
                    n_cp = adv(r_cp);
                end
            end
            MODE_TARGET:    we.target = 1'b1;
            MODE_COMMIT_ST: we.cs = 32'(r_slot) < SLOTS;
            MODE_HIT:       we.hit = 1'b1;
            MODE_CFI:       we.cfi = 1'b1;
            MODE_MISPRED:   we.mp = 1'b1;
            MODE_RECOVER: begin
                case (r_which)
                    SEL_S1:       n_s1 = idx;
                    SEL_S2:       n_s2 = idx;
                    SEL_S3:       n_s3 = idx;
                    SEL_FETCH:    n_fp = idx;
                    SEL_PREFETCH: n_pp = idx;
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (!r_vld) begin
            n_s1 = r_s1;
            n_s2 = r_s2;
            n_s3 = r_s3;
            n_fp = r_fp;
            n_pp = r_pp;
            n_cp = r_cp;
            fill = 1'b0;
            we   = '0;
        end
        if (fill) begin
            we = '{start: 1'b1, target: 1'b1, cfi: 1'b1, hit: 1'b1, cs: 1'b1, mp: 1'b1};
        end

        w_cfi = {r_cfi_valid, r_cfi_offset};

        // slot of the mispredicted instruction inside the block
        mp_diff = r_pc - rd_start;
        mp_off  = mp_diff[63:1];
        w_cs    = rd_cs;
        w_mp    = rd_mp;
        for (int i = 0; i < SLOTS; i++) begin
            if (fill || 32'(r_slot) == i) begin
                w_cs[2*i +: 2] = r_cs;
            end
        end
        if (fill) begin
            w_mp = '0;
        end else if (mp_off < 63'(SLOTS)) begin
            w_mp[mp_off[SIW-1:0]] = r_flag;
        end
        if (r_mode == MODE_MISPRED && !(mp_off < 63'(SLOTS))) begin
            we.mp = 1'b0;
        end
        nx = adv(n_cp);
    end

    ftqp_store u_store (
        .i_clk       (i_clk),
        .i_addr      (slot_of(rep)),
        .i_we        (we),
        .i_start_d   (r_start),
        .i_target_d  (r_target),
        .i_cfi_d     (w_cfi),
        .i_hit_d     (r_hit),
        .i_cs_d      (w_cs),
        .i_mp_d      (w_mp),
        .i_head      (slot_of(n_cp)),
        .i_next      (slot_of(nx)),
        .o_start     (rd_start),
        .o_target    (rd_target),
        .o_cfi       (rd_cfi),
        .o_hit       (rd_hit),
        .o_cs        (rd_cs),
        .o_mp        (rd_mp),
        .o_head_done (head_done),
        .o_next_done (next_done),
        .o_head_upd  (head_upd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_s1    <= '0;
            r_s2    <= '0;
            r_s3    <= '0;
            r_fp    <= '0;
            r_pp    <= '0;
            r_cp    <= '0;
        end else begin
            o_valid <= r_vld;
            r_s1    <= n_s1;
            r_s2    <= n_s2;
            r_s3    <= n_s3;
            r_fp    <= n_fp;
            r_pp    <= n_pp;
            r_cp    <= n_cp;
        end
        if (r_vld) begin
            o_out_index       <= 6'(rep);
            o_out_start_addr  <= we.start ? r_start : rd_start;
            o_out_target_addr <= we.target ? r_target : rd_target;
            {o_out_cfi_valid, o_out_cfi_offset} <= we.cfi ? w_cfi : rd_cfi;
            o_out_hit_status  <= we.hit ? r_hit : rd_hit;
            o_mispred_bits    <= 16'(we.mp ? w_mp : rd_mp);
            o_queue_flags     <= {is_full(n_s1, n_cp), n_cp == n_fp,
                                  n_s1 == n_pp, n_s1 == n_fp};
            o_commit_flags    <= {head_upd,
                                  (n_cp != n_fp) && (nx != n_fp) && next_done,
                                  (n_cp != n_fp) && head_done};
            o_order_flags     <= {is_before(idx, n_pp), is_before(idx, n_fp)};
        end
    end

    // a push into a full queue leaves stage one where it was
    a_push_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && r_mode == MODE_PUSH && is_full(r_s1, r_cp)) |=> (r_s1 == $past(r_s1)))
        else $error("push into full queue moved stage one pointer");

    a_head_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_queue_flags[2] && (o_commit_flags[0] || o_commit_flags[1])))
        else $error("commit flags set on empty commit window");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("transfer produced no result");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |=> (32'(r_fp) < WRAP && 32'(r_cp) < WRAP && 32'(r_s1) < WRAP))
        else $error("pointer out of wrap range");

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// checks the fetch target queue pointer unit against its own predictor:
// the queue is first filled so no unwritten entry is ever read, then a
// directed set of corner cases and random command streams under several
// sender idle rates; every result is compared field by field
// ----------------------------------------------------------------------------
module tb;
    import ftqp_pkg::*;

    localparam int QDEPTH = 32;
    localparam int QSLOTS = 16;

    typedef struct packed {
        logic [3:0]  mode;
        logic [5:0]  index;
        logic [2:0]  which;
        logic [63:0] start_addr;
        logic [63:0] target_addr;
        logic        cfi_valid;
        logic [3:0]  cfi_offset;
        logic [1:0]  hit_st;
        logic [3:0]  slot;
        logic [1:0]  commit_state;
        logic        flag;
        logic [63:0] pc;
    } t_cmd;

    typedef struct packed {
        logic [5:0]  index;
        logic [63:0] start_addr;
        logic [63:0] target_addr;
        logic        cfi_valid;
        logic [3:0]  cfi_offset;
        logic [1:0]  hit_st;
        logic [15:0] mispred;
        logic [3:0]  queue_flags;
        logic [2:0]  commit_flags;
        logic [1:0]  order_flags;
    } t_res;

    class ftq_scoreboard;
        logic [63:0] start_mem [QDEPTH];
        logic [63:0] target_mem [QDEPTH];
        logic [4:0]  cfi_mem [QDEPTH];
        logic [1:0]  hit_mem [QDEPTH];
        logic [31:0] cs_mem [QDEPTH];
        logic [15:0] mp_mem [QDEPTH];
        logic [5:0]  stage_ptr [3];
        logic [5:0]  fch_ptr, pf_ptr, cmt_ptr;
        t_res        expected_q [$];
        int          mismatches;
        int          checked;

        function new();
            for (int i = 0; i < 3; i++) stage_ptr[i] = '0;
            fch_ptr = '0;
            pf_ptr = '0;
            cmt_ptr = '0;
            mismatches = 0;
            checked = 0;
        endfunction

        function logic [5:0] bump(logic [5:0] p);
            return (p == 6'(2 * QDEPTH - 1)) ? 6'd0 : p + 6'd1;
        endfunction

        function bit is_before(logic [5:0] idx, logic [5:0] ptr);
            if (idx[5] == ptr[5]) return idx[4:0] < ptr[4:0];
            return idx[4:0] > ptr[4:0];
        endfunction

        // no slot left valid or unfetched
        function bit done_entry(int e);
            for (int i = 0; i < QSLOTS; i++)
                if (cs_mem[e][2*i]) return 0;
            return 1;
        endfunction

        function void fill(int e, t_cmd c);
            start_mem[e] = c.start_addr;
            target_mem[e] = c.target_addr;
            cfi_mem[e] = {c.cfi_valid, c.cfi_offset};
            hit_mem[e] = c.hit_st;
            cs_mem[e] = {QSLOTS{c.commit_state}};
            mp_mem[e] = '0;
        endfunction

        function void note_command(t_cmd c);
            logic [5:0]  rep;
            logic [5:0]  nx;
            logic [63:0] off;
            int          e, r, ce;
            bit          full;
            t_res        x;
            rep = c.index;
            e = c.index % QDEPTH;
            full = (6'(stage_ptr[0] - cmt_ptr) == 6'(QDEPTH));
            case (c.mode)
                MODE_PUSH: begin
                    rep = stage_ptr[0];
                    if (!full) begin
                        fill(rep % QDEPTH, c);
                        stage_ptr[0] = bump(rep);
                    end
                end
                MODE_S2_UPDATE, MODE_S3_UPDATE: begin
                    rep = stage_ptr[c.mode];
                    fill(rep % QDEPTH, c);
                    stage_ptr[c.mode] = bump(rep);
                end
                MODE_FETCH_POP: begin
                    rep = fch_ptr;
                    if (stage_ptr[0] != fch_ptr) fch_ptr = bump(rep);
                end
                MODE_PF_POP: begin
                    rep = pf_ptr;
                    if (stage_ptr[0] != pf_ptr) pf_ptr = bump(rep);
                end
                MODE_RETIRE: begin
                    rep = cmt_ptr;
                    if (cmt_ptr != fch_ptr) cmt_ptr = bump(rep);
                end
                MODE_TARGET: target_mem[e] = c.target_addr;
                MODE_COMMIT_ST: begin
                    if (c.slot < QSLOTS) cs_mem[e][2*c.slot +: 2] = c.commit_state;
                end
                MODE_HIT: hit_mem[e] = c.hit_st;
                MODE_CFI: cfi_mem[e] = {c.cfi_valid, c.cfi_offset};
                MODE_MISPRED: begin
                    off = (c.pc - start_mem[e]) >> 1;
                    if (off < QSLOTS) mp_mem[e][off[3:0]] = c.flag;
                end
                MODE_RECOVER: begin
                    case (c.which)
                        SEL_S1, SEL_S2, SEL_S3: stage_ptr[c.which] = c.index;
                        SEL_FETCH: fch_ptr = c.index;
                        SEL_PREFETCH: pf_ptr = c.index;
                        default: ;
                    endcase
                end
                default: ;
            endcase
            r = rep % QDEPTH;
            x.index = rep;
            x.start_addr = start_mem[r];
            x.target_addr = target_mem[r];
            x.cfi_valid = cfi_mem[r][4];
            x.cfi_offset = cfi_mem[r][3:0];
            x.hit_st = hit_mem[r];
            x.mispred = mp_mem[r];
            x.queue_flags = {6'(stage_ptr[0] - cmt_ptr) == 6'(QDEPTH),
                             cmt_ptr == fch_ptr, stage_ptr[0] == pf_ptr,
                             stage_ptr[0] == fch_ptr};
            ce = cmt_ptr % QDEPTH;
            nx = bump(cmt_ptr);
            x.commit_flags = '0;
            if (cmt_ptr != fch_ptr) begin
                x.commit_flags[0] = done_entry(ce);
                x.commit_flags[1] = (nx != fch_ptr) && done_entry(nx % QDEPTH);
            end
            x.commit_flags[2] = (hit_mem[ce] == HIT_CODE) || cfi_mem[ce][4];
            x.order_flags = {is_before(c.index, pf_ptr), is_before(c.index, fch_ptr)};
            expected_q.insert(expected_q.size(), x);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            mismatches++;
            $display("mismatch on %s: got %h, expected %h", what, got, want);
        endtask

        task check_result(t_res got);
            t_res w;
            if (expected_q.size() == 0) begin
                report("unexpected result", got.index, 0);
                return;
            end
            w = expected_q.pop_front();
            checked++;
            if (got.index !== w.index) report("index", got.index, w.index);
            if (got.start_addr !== w.start_addr)
                report("start_addr", got.start_addr, w.start_addr);
            if (got.target_addr !== w.target_addr)
                report("target_addr", got.target_addr, w.target_addr);
            if (got.cfi_valid !== w.cfi_valid) report("cfi_valid", got.cfi_valid, w.cfi_valid);
            if (got.cfi_offset !== w.cfi_offset)
                report("cfi_offset", got.cfi_offset, w.cfi_offset);
            if (got.hit_st !== w.hit_st)
                report("hit code", got.hit_st, w.hit_st);
            if (got.mispred !== w.mispred) report("mispred_bits", got.mispred, w.mispred);
            if (got.queue_flags !== w.queue_flags)
                report("queue_flags", got.queue_flags, w.queue_flags);
            if (got.commit_flags !== w.commit_flags)
                report("commit_flags", got.commit_flags, w.commit_flags);
            if (got.order_flags !== w.order_flags)
                report("order_flags", got.order_flags, w.order_flags);
        endtask
    endclass

    logic i_clk, i_rst_n, start, busy, o_valid;
    t_cmd cmd;
    logic [5:0]  o_out_index;
    logic [63:0] o_out_start_addr, o_out_target_addr;
    logic        o_out_cfi_valid;
    logic [3:0]  o_out_cfi_offset;
    logic [1:0]  o_out_hit_status;
    logic [15:0] o_mispred_bits;
    logic [3:0]  o_queue_flags;
    logic [2:0]  o_commit_flags;
    logic [1:0]  o_order_flags;

    ftq_scoreboard sb;
    int idle_pct;

    fetch_target_queue_pointers_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(cmd.mode), .i_index(cmd.index), .i_which_pointer(cmd.which),
        .i_start_addr(cmd.start_addr), .i_target_addr(cmd.target_addr),
        .i_cfi_valid(cmd.cfi_valid), .i_cfi_offset(cmd.cfi_offset),
        .i_hit_status(cmd.hit_st), .i_slot(cmd.slot),
        .i_commit_state(cmd.commit_state), .i_flag(cmd.flag), .i_pc(cmd.pc),
        .o_valid(o_valid), .o_out_index(o_out_index),
        .o_out_start_addr(o_out_start_addr), .o_out_target_addr(o_out_target_addr),
        .o_out_cfi_valid(o_out_cfi_valid), .o_out_cfi_offset(o_out_cfi_offset),
        .o_out_hit_status(o_out_hit_status), .o_mispred_bits(o_mispred_bits),
        .o_queue_flags(o_queue_flags), .o_commit_flags(o_commit_flags),
        .o_order_flags(o_order_flags)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("FAILED: results differ");
        $finish;
    end

    // results first, then the command transfer of this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                sb.check_result({o_out_index, o_out_start_addr, o_out_target_addr,
                                 o_out_cfi_valid, o_out_cfi_offset, o_out_hit_status,
                                 o_mispred_bits, o_queue_flags, o_commit_flags,
                                 o_order_flags});
            if (start && !busy) sb.note_command(cmd);
        end
    end

    function automatic t_cmd rand_cmd(logic [3:0] m);
        t_cmd c;
        c.mode = m;
        c.index = 6'($urandom_range(0, 63));
        c.which = 3'($urandom_range(0, 7));
        c.start_addr = {$urandom, $urandom};
        c.target_addr = {$urandom, $urandom};
        c.cfi_valid = 1'($urandom);
        c.cfi_offset = 4'($urandom);
        c.hit_st = 2'($urandom);
        c.slot = 4'($urandom);
        c.commit_state = 2'($urandom);
        c.flag = 1'($urandom);
        c.pc = {$urandom, $urandom};
        return c;
    endfunction

    task send(t_cmd c);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        cmd <= c;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task send_op(logic [3:0] m, logic [5:0] idx, logic [2:0] w);
        t_cmd c;
        c = rand_cmd(m);
        c.index = idx;
        c.which = w;
        send(c);
    endtask

    task send_random();
        t_cmd c;
        int   pick;
        pick = $urandom_range(0, 99);
        // pipeline-shaped traffic most of the time, rarer writes and repairs
        if (pick < 22) c = rand_cmd(MODE_PUSH);
        else if (pick < 30) c = rand_cmd(4'($urandom_range(MODE_S2_UPDATE, MODE_S3_UPDATE)));
        else if (pick < 46) c = rand_cmd(4'($urandom_range(MODE_FETCH_POP, MODE_PF_POP)));
        else if (pick < 58) c = rand_cmd(MODE_RETIRE);
        else if (pick < 92) c = rand_cmd(4'($urandom_range(MODE_TARGET, MODE_MISPRED)));
        else if (pick < 95) c = rand_cmd(MODE_RECOVER);
        else c = rand_cmd(4'($urandom_range(MODE_READ, 15)));
        if (c.mode == MODE_COMMIT_ST && $urandom_range(0, 1)) c.commit_state = 2'd2;
        if (c.mode == MODE_MISPRED && $urandom_range(0, 3) != 0)
            c.pc = sb.start_mem[c.index % QDEPTH] + 64'(2 * $urandom_range(0, 17));
        send(c);
    endtask

    initial begin
        t_cmd c;
        int   waited;
        sb = new();
        i_rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        idle_pct = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill every entry so nothing unwritten is ever reported
        for (int i = 0; i < QDEPTH; i++) begin
            c = rand_cmd(MODE_PUSH);
            if (i == 0) begin
                c.start_addr = '0;
                c.target_addr = '1;
                c.commit_state = 2'd2;
            end
            if (i == 1) begin
                c.start_addr = '1;
                c.target_addr = '0;
            end
            send(c);
        end
        send_op(MODE_PUSH, 6'd0, SEL_S1);             // full, ignored
        send_op(MODE_S2_UPDATE, 6'd0, SEL_S1);
        send_op(MODE_S3_UPDATE, 6'd63, SEL_S1);
        send_op(MODE_RECOVER, 6'd32, SEL_FETCH);      // fetch catches up with s1
        send_op(MODE_FETCH_POP, 6'd0, SEL_S1);        // empty, no move
        send_op(MODE_RECOVER, 6'd32, SEL_PREFETCH);
        send_op(MODE_PF_POP, 6'd63, SEL_S1);
        send_op(MODE_RETIRE, 6'd0, SEL_S1);
        send_op(MODE_RECOVER, 6'd1, SEL_FETCH);
        send_op(MODE_RETIRE, 6'd0, SEL_S1);
        send_op(MODE_RETIRE, 6'd0, SEL_S1);           // commit empty, no move
        send_op(MODE_RECOVER, 6'd5, 3'd5);            // bad selector
        send_op(MODE_RECOVER, 6'd5, 3'd7);
        c = rand_cmd(MODE_COMMIT_ST); c.index = 6'd1; c.slot = 4'd15; send(c);
        c = rand_cmd(MODE_MISPRED); c.index = 6'd33; c.pc = sb.start_mem[1] + 64'd30;
        c.flag = 1'b1; send(c);
        c = rand_cmd(MODE_MISPRED); c.index = 6'd33; c.pc = sb.start_mem[1] + 64'd32;
        send(c);                                      // slot past the block
        c = rand_cmd(MODE_MISPRED); c.index = 6'd1; c.pc = sb.start_mem[1] + 64'd30;
        c.flag = 1'b0; send(c);
        send_op(MODE_TARGET, 6'd63, SEL_S1);
        send_op(MODE_HIT, 6'd2, SEL_S1);
        send_op(MODE_CFI, 6'd40, SEL_S1);
        send_op(MODE_READ, 6'd63, SEL_S1);
        send_op(4'd13, 6'd0, SEL_S1);
        send_op(4'd15, 6'd31, SEL_S1);

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 65 : (ph == 3) ? 7 : 0;
            for (int i = 0; i < 225; i++) send_random();
        end
        start <= 1'b0;

        waited = 0;
        while (sb.expected_q.size() != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (5) @(posedge i_clk);
        $display("covered %0d results from directed corner cases and random traffic",
                 sb.checked);
        $display("with sender idle rates of 0, 65 and 7 percent");
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
